>>> sv/mbor_pkg.sv
`timescale 1ns / 1ps

package mbor_pkg;

  localparam int NumButtons  = 5;
  localparam int TimeBits    = 32;
  localparam int SeedBits    = 31;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 5;

  typedef enum logic [2:0] {
    OpTick  = 3'd0,
    OpPhys  = 3'd1,
    OpForce = 3'd2,
    OpClick = 3'd3,
    OpMove  = 3'd4,
    OpWheel = 3'd5,
    OpRead  = 3'd6
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLockX   = 3'd0,
    CfgLockY   = 3'd1,
    CfgBtnLock = 3'd2,
    CfgNotify  = 3'd3
  } cfg_e;

  // 31-bit LCG
  localparam logic [SeedBits-1:0] LcgMul  = 31'd1103515245;
  localparam logic [SeedBits-1:0] LcgInc  = 31'd12345;
  localparam logic [SeedBits-1:0] SeedRst = 31'h12345678;
  // two steps folded into one affine map
  localparam logic [SeedBits-1:0] LcgMul2 = SeedBits'(64'(LcgMul) * 64'(LcgMul));
  localparam logic [SeedBits-1:0] LcgInc2 =
    SeedBits'(64'(LcgMul) * 64'(LcgInc) + 64'(LcgInc));

  function automatic logic [SeedBits-1:0] lcg_step(logic [SeedBits-1:0] s);
    return SeedBits'(s * LcgMul + LcgInc);
  endfunction

  function automatic logic [SeedBits-1:0] lcg_jump2(logic [SeedBits-1:0] s);
    return SeedBits'(s * LcgMul2 + LcgInc2);
  endfunction

  localparam logic [SeedBits-1:0] SeedRst1 = lcg_step(SeedRst);
  localparam logic [SeedBits-1:0] SeedRst2 = lcg_step(SeedRst1);

  // both duration windows are 51 ms wide
  localparam int RandRange  = 51;
  localparam int RandShift  = 16;
  localparam int RandBits   = SeedBits - RandShift;
  localparam int RecipShift = 21;
  localparam int RecipMul   = (2 ** RecipShift + RandRange - 1) / RandRange;
  localparam int ReleaseMin = 125;
  localparam int PressMin   = 75;

  // (v mod 51) via reciprocal multiply, exact for 15-bit v
  function automatic logic [5:0] rand_mod(logic [RandBits-1:0] v);
    logic [31:0] prod;
    logic [9:0]  quo;
    logic [15:0] rem;
    prod = 32'(v) * 32'(RecipMul);
    quo  = 10'(prod >> RecipShift);
    rem  = 16'(v) - 16'(quo) * 16'(RandRange);
    return 6'(rem);
  endfunction

  typedef struct packed {
    op_e                  opcode;
    logic [TimeBits-1:0]  now_ms;
    logic [2:0]           button_index;
    logic                 press;
    logic [4:0]           physical_mask;
    logic signed [15:0]   move_dx;
    logic signed [15:0]   move_dy;
    logic signed [7:0]    wheel_delta;
  } item_t;

  typedef struct packed {
    logic [NumButtons-1:0] pressed;
    logic [NumButtons-1:0] forced;
  } btn_state_t;

  typedef struct packed {
    logic one;
    logic two;
  } draw_req_t;

endpackage

>>> sv/mbor_if.sv
`timescale 1ns / 1ps

interface mbor_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [31:0]        now_ms;
  logic [2:0]         button_index;
  logic               press;
  logic [4:0]         physical_mask;
  logic signed [15:0] move_dx;
  logic signed [15:0] move_dy;
  logic signed [7:0]  wheel_delta;

  modport source (
    output valid, opcode, now_ms, button_index, press, physical_mask,
           move_dx, move_dy, wheel_delta,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, button_index, press, physical_mask,
           move_dx, move_dy, wheel_delta,
    output ready
  );
endinterface

interface mbor_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        report_buttons;
  logic signed [7:0] report_x;
  logic signed [7:0] report_y;
  logic signed [7:0] report_wheel;
  logic              mask_changed;
  logic              any_forced;

  modport source (
    output valid, report_buttons, report_x, report_y, report_wheel,
           mask_changed, any_forced,
    input  ready
  );
  modport sink (
    input  valid, report_buttons, report_x, report_y, report_wheel,
           mask_changed, any_forced,
    output ready
  );
endinterface

>>> sv/mbor_lcg.sv
`timescale 1ns / 1ps

// Keeps the seeds for the next two draws so a click can take both at once.
module mbor_lcg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  mbor_pkg::draw_req_t   req_i,
  output logic [5:0]            rnd1_o,
  output logic [5:0]            rnd2_o
);

  logic [mbor_pkg::SeedBits-1:0] n1_q, n1_d;
  logic [mbor_pkg::SeedBits-1:0] n2_q, n2_d;

  always_comb begin
    n1_d = n1_q;
    n2_d = n2_q;
    if (req_i.two) begin
      n1_d = mbor_pkg::lcg_step(n2_q);
      n2_d = mbor_pkg::lcg_jump2(n2_q);
    end else if (req_i.one) begin
      n1_d = n2_q;
      n2_d = mbor_pkg::lcg_step(n2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q <= mbor_pkg::SeedRst1;
      n2_q <= mbor_pkg::SeedRst2;
    end else if (adv_i) begin
      n1_q <= n1_d;
      n2_q <= n2_d;
    end
  end

  assign rnd1_o = mbor_pkg::rand_mod(n1_q[mbor_pkg::SeedBits-1:mbor_pkg::RandShift]);
  assign rnd2_o = mbor_pkg::rand_mod(n2_q[mbor_pkg::SeedBits-1:mbor_pkg::RandShift]);

endmodule

>>> sv/mbor_buttons.sv
`timescale 1ns / 1ps

module mbor_buttons (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  mbor_pkg::item_t                 item_i,
  input  logic [mbor_pkg::NumButtons-1:0] lock_i,
  input  logic [5:0]                      rnd1_i,
  input  logic [5:0]                      rnd2_i,
  output mbor_pkg::btn_state_t            state_o,
  output mbor_pkg::draw_req_t             req_o
);

  localparam int Nb = mbor_pkg::NumButtons;
  localparam int Tb = mbor_pkg::TimeBits;

  logic [Nb-1:0] pressed_q, pressed_d;
  logic [Nb-1:0] forced_q, forced_d;
  logic [Nb-1:0] clicking_q, clicking_d;
  logic [Nb-1:0] dl_we, click_we;
  logic [Nb-1:0] rel_hit;
  logic [Nb-1:0] phys_q, phys_d;
  logic [Tb-1:0] deadline_q [Nb];
  logic [Tb-1:0] click_rel_q [Nb];
  logic [Tb-1:0] click_end_q [Nb];

  logic [Tb-1:0] now;
  logic [Tb-1:0] rel_time;
  logic [Tb-1:0] click_rel;
  logic [Tb-1:0] click_end;
  logic          idx_ok;

  assign now       = Tb'(item_i.now_ms);
  assign rel_time  = now + Tb'(mbor_pkg::ReleaseMin) + Tb'(rnd1_i);
  assign click_rel = now + Tb'(mbor_pkg::PressMin) + Tb'(rnd1_i);
  assign click_end = now + Tb'(mbor_pkg::PressMin + mbor_pkg::ReleaseMin)
                     + Tb'(rnd1_i) + Tb'(rnd2_i);
  assign idx_ok    = 4'(item_i.button_index) < 4'(Nb);

  always_comb begin
    pressed_d  = pressed_q;
    forced_d   = forced_q;
    clicking_d = clicking_q;
    phys_d     = phys_q;
    dl_we      = '0;
    click_we   = '0;
    rel_hit    = '0;
    if (item_i.opcode == mbor_pkg::OpPhys) begin
      phys_d = Nb'(item_i.physical_mask);
    end
    for (int i = 0; i < Nb; i++) begin
      case (item_i.opcode)
        mbor_pkg::OpTick: begin
          if (clicking_q[i]) begin
            if (now >= click_end_q[i]) begin
              clicking_d[i] = 1'b0;
              forced_d[i]   = 1'b0;
              pressed_d[i]  = phys_q[i];
            end else if (now >= click_rel_q[i]) begin
              pressed_d[i] = 1'b0;
            end
          end else if (forced_q[i] && !pressed_q[i]) begin
            // timed release pending
            if (now >= deadline_q[i]) begin
              forced_d[i] = 1'b0;
              if (!lock_i[i]) pressed_d[i] = phys_q[i];
            end
          end else if (!forced_q[i] && !lock_i[i]) begin
            pressed_d[i] = phys_q[i];
          end
        end
        mbor_pkg::OpPhys: begin
          if (!forced_q[i] && !lock_i[i]) pressed_d[i] = item_i.physical_mask[i];
        end
        mbor_pkg::OpForce: begin
          if (item_i.button_index == 3'(i)) begin
            if (item_i.press) begin
              pressed_d[i]  = 1'b1;
              forced_d[i]   = 1'b1;
              clicking_d[i] = 1'b0;
            end else if (forced_q[i] && pressed_q[i]) begin
              pressed_d[i]  = 1'b0;
              clicking_d[i] = 1'b0;
              dl_we[i]      = 1'b1;
              rel_hit[i]    = 1'b1;
            end
          end
        end
        mbor_pkg::OpClick: begin
          if (item_i.button_index == 3'(i)) begin
            clicking_d[i] = 1'b1;
            pressed_d[i]  = 1'b1;
            forced_d[i]   = 1'b1;
            click_we[i]   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign req_o.one = |rel_hit;
  assign req_o.two = (item_i.opcode == mbor_pkg::OpClick) && idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= '0;
      forced_q   <= '0;
      clicking_q <= '0;
      phys_q     <= '0;
    end else if (adv_i) begin
      pressed_q  <= pressed_d;
      forced_q   <= forced_d;
      clicking_q <= clicking_d;
      phys_q     <= phys_d;
    end
  end

  // deadlines are only read while the matching state bit is set
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Nb; i++) begin
      if (adv_i && dl_we[i]) deadline_q[i] <= rel_time;
      if (adv_i && click_we[i]) begin
        click_rel_q[i] <= click_rel;
        click_end_q[i] <= click_end;
      end
    end
  end

  assign state_o.pressed = pressed_d;
  assign state_o.forced  = forced_d;

endmodule

>>> sv/mbor_motion.sv
`timescale 1ns / 1ps

module mbor_motion (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  mbor_pkg::item_t   item_i,
  input  logic              lock_x_i,
  input  logic              lock_y_i,
  output logic signed [7:0] x_o,
  output logic signed [7:0] y_o,
  output logic signed [7:0] wheel_o
);

  logic signed [31:0] x_q, x_d;
  logic signed [31:0] y_q, y_d;
  logic signed [7:0]  w_q, w_d;
  logic [32:0]        x_sum, y_sum;
  logic [8:0]         w_sum;
  logic [39:0]        x_dr, y_dr;

  function automatic logic [31:0] sat32(logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                r = s[31:0];
    return r;
  endfunction

  // {chunk, remainder}
  function automatic logic [39:0] drain(logic signed [31:0] acc);
    logic [39:0] r;
    if (acc > 32'sd127)       r = {8'h7F, 32'(acc - 32'sd127)};
    else if (acc < -32'sd128) r = {8'h80, 32'(acc + 32'sd128)};
    else                      r = {acc[7:0], 32'd0};
    return r;
  endfunction

  assign x_sum = {x_q[31], x_q} + {{17{item_i.move_dx[15]}}, item_i.move_dx};
  assign y_sum = {y_q[31], y_q} + {{17{item_i.move_dy[15]}}, item_i.move_dy};
  assign w_sum = {w_q[7], w_q} + {item_i.wheel_delta[7], item_i.wheel_delta};
  assign x_dr  = drain(x_q);
  assign y_dr  = drain(y_q);

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    w_d     = w_q;
    x_o     = '0;
    y_o     = '0;
    wheel_o = '0;
    case (item_i.opcode)
      mbor_pkg::OpMove: begin
        if (!lock_x_i) x_d = sat32(x_sum);
        if (!lock_y_i) y_d = sat32(y_sum);
      end
      mbor_pkg::OpWheel: begin
        if (w_sum[8] != w_sum[7]) w_d = w_sum[8] ? 8'sh80 : 8'sh7F;
        else                      w_d = w_sum[7:0];
      end
      mbor_pkg::OpRead: begin
        x_o     = x_dr[39:32];
        y_o     = y_dr[39:32];
        wheel_o = w_q;
        x_d     = x_dr[31:0];
        y_d     = y_dr[31:0];
        w_d     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      w_q <= '0;
    end else if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
      w_q <= w_d;
    end
  end

endmodule

>>> sv/mouse_button_override_report.sv
`timescale 1ns / 1ps
// An accepted transaction lands in the input register and its result loads into the
// result register when that register is empty or its result is being taken.
// Throughput: one transaction per cycle; input ready drops only while a result
// waits in a full result register. The LCG keeps two seeds ahead.
// Reset (async, active low) clears buttons, accumulators and config and reloads the seeds.
module mouse_button_override_report (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mbor_in_if.sink                           item_i,
  mbor_out_if.source                        report_o,
  input  logic                              cfg_we_i,
  input  logic [mbor_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [mbor_pkg::CfgDataBits-1:0]  cfg_data_i
);

  localparam int Nb = mbor_pkg::NumButtons;

  mbor_pkg::item_t      item_q;
  logic                 iv_q;
  logic                 ov_q;
  logic                 adv;
  mbor_pkg::btn_state_t btn;
  mbor_pkg::draw_req_t  req;
  logic [5:0]           rnd1, rnd2;
  logic signed [7:0]    rx, ry, rw;

  logic                 lock_x_q, lock_y_q, notify_q;
  logic [Nb-1:0]        btn_lock_q;
  logic [Nb-1:0]        last_q;
  logic                 changed;

  logic [4:0]           res_buttons_q;
  logic signed [7:0]    res_x_q, res_y_q, res_w_q;
  logic                 res_changed_q, res_forced_q;

  assign adv          = iv_q && (!ov_q || report_o.ready);
  assign item_i.ready = !iv_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      iv_q <= 1'b1;
    end else if (adv) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.opcode        <= mbor_pkg::op_e'(item_i.opcode);
      item_q.now_ms        <= mbor_pkg::TimeBits'(item_i.now_ms);
      item_q.button_index  <= item_i.button_index;
      item_q.press         <= item_i.press;
      item_q.physical_mask <= item_i.physical_mask;
      item_q.move_dx       <= item_i.move_dx;
      item_q.move_dy       <= item_i.move_dy;
      item_q.wheel_delta   <= item_i.wheel_delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_x_q   <= 1'b0;
      lock_y_q   <= 1'b0;
      btn_lock_q <= '0;
      notify_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (mbor_pkg::cfg_e'(cfg_idx_i))
        mbor_pkg::CfgLockX:   lock_x_q   <= cfg_data_i[0];
        mbor_pkg::CfgLockY:   lock_y_q   <= cfg_data_i[0];
        mbor_pkg::CfgBtnLock: btn_lock_q <= Nb'(cfg_data_i);
        mbor_pkg::CfgNotify:  notify_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mbor_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (req),
    .rnd1_o (rnd1),
    .rnd2_o (rnd2)
  );

  mbor_buttons u_buttons (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (item_q),
    .lock_i  (btn_lock_q),
    .rnd1_i  (rnd1),
    .rnd2_i  (rnd2),
    .state_o (btn),
    .req_o   (req)
  );

  mbor_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (item_q),
    .lock_x_i (lock_x_q),
    .lock_y_i (lock_y_q),
    .x_o      (rx),
    .y_o      (ry),
    .wheel_o  (rw)
  );

  assign changed = (item_q.opcode == mbor_pkg::OpTick) && notify_q && (btn.pressed != last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      last_q <= '0;
    end else begin
      if (adv) begin
        ov_q <= 1'b1;
        if (changed) last_q <= btn.pressed;
      end else if (report_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_buttons_q <= 5'(btn.pressed);
      res_x_q       <= rx;
      res_y_q       <= ry;
      res_w_q       <= rw;
      res_changed_q <= changed;
      res_forced_q  <= |btn.forced;
    end
  end

  assign report_o.valid          = ov_q;
  assign report_o.report_buttons = res_buttons_q;
  assign report_o.report_x       = res_x_q;
  assign report_o.report_y       = res_y_q;
  assign report_o.report_wheel   = res_w_q;
  assign report_o.mask_changed   = res_changed_q;
  assign report_o.any_forced     = res_forced_q;

endmodule

>>> tb/sv/tb_mouse_button_override_report.sv
`timescale 1ns / 1ps

module tb_mouse_button_override_report;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 4;
  localparam int DrainCycles = 4;
  localparam int StallLimit  = 2000;
  localparam int Phases      = 8;
  localparam int PhaseItems  = 235;

  localparam logic [2:0] OpUnused = 3'd7;

  localparam longint unsigned LcgMul   = 64'd1103515245;
  localparam longint unsigned LcgInc   = 64'd12345;
  localparam logic [30:0]     SeedInit = 31'h12345678;
  localparam int unsigned     PressLo  = 75;
  localparam int unsigned     PressHi  = 125;
  localparam int unsigned     RelLo    = 125;
  localparam int unsigned     RelHi    = 175;
  localparam int              ChunkMax = 127;
  localparam int              ChunkMin = -128;

  typedef struct packed {
    logic [4:0]        report_buttons;
    logic signed [7:0] report_x;
    logic signed [7:0] report_y;
    logic signed [7:0] report_wheel;
    logic              mask_changed;
    logic              any_forced;
  } report_t;

  typedef struct {
    mbor_pkg::item_t it;
    bit              typed;
    report_t         want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                             cfg_we;
  logic [mbor_pkg::CfgIdxBits-1:0]  cfg_idx;
  logic [mbor_pkg::CfgDataBits-1:0] cfg_data;

  mbor_in_if  item_if ();
  mbor_out_if report_if ();

  mouse_button_override_report i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .report_o   (report_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // shadow of the block's button and accumulator state
  logic [mbor_pkg::NumButtons-1:0] btn_down     = '0;
  logic [mbor_pkg::NumButtons-1:0] btn_forced   = '0;
  logic [mbor_pkg::NumButtons-1:0] btn_clicking = '0;
  logic [31:0] rel_deadline [mbor_pkg::NumButtons] = '{default: '0};
  logic [31:0] click_rel_at [mbor_pkg::NumButtons] = '{default: '0};
  logic [31:0] click_end_at [mbor_pkg::NumButtons] = '{default: '0};
  logic [30:0]        lcg_state  = SeedInit;
  logic [4:0]         phys_latch = '0;
  logic signed [31:0] acc_x      = '0;
  logic signed [31:0] acc_y      = '0;
  logic signed [7:0]  acc_wheel  = '0;
  logic [4:0]         last_mask  = '0;

  logic       lock_x_q   = 1'b0;
  logic       lock_y_q   = 1'b0;
  logic [4:0] btn_lock_q = '0;
  logic       notify_q   = 1'b0;

  report_t   expected_reports [$];
  stim_row_t dir_rows [$];
  report_t   want_rep;
  int        mismatches  = 0;
  int        quiet_cycles = 0;
  int        sink_hold   = 0;
  bit        no_idle     = 1'b0;
  logic [31:0] sim_ms;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] draw_ms(int unsigned lo, int unsigned hi);
    lcg_state = 31'(64'(lcg_state) * LcgMul + LcgInc);
    return lo + (32'(lcg_state >> 16) % (hi - lo + 1));
  endfunction

  function automatic logic signed [7:0] drain_chunk(inout logic signed [31:0] acc);
    logic signed [7:0] c;
    if (acc > ChunkMax) begin
      c = 8'(ChunkMax);
      acc = acc - ChunkMax;
    end else if (acc < ChunkMin) begin
      c = 8'(ChunkMin);
      acc = acc - ChunkMin;
    end else begin
      c = acc[7:0];
      acc = '0;
    end
    return c;
  endfunction

  function automatic logic signed [31:0] add_sat32(logic signed [31:0] acc,
                                                   logic signed [15:0] d);
    logic signed [32:0] s;
    s = $signed({acc[31], acc}) + $signed({{17{d[15]}}, d});
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic void tick_buttons(logic [31:0] now);
    for (int i = 0; i < mbor_pkg::NumButtons; i++) begin
      if (btn_clicking[i]) begin
        if (now >= click_end_at[i]) begin
          // click over: back to the physical bit even if locked
          btn_clicking[i] = 1'b0;
          btn_forced[i]   = 1'b0;
          click_rel_at[i] = '0;
          click_end_at[i] = '0;
          btn_down[i]     = phys_latch[i];
        end else if (now >= click_rel_at[i]) begin
          btn_down[i] = 1'b0;
        end
      end else if (btn_forced[i] && !btn_down[i]) begin
        if (now >= rel_deadline[i]) begin
          btn_forced[i]   = 1'b0;
          rel_deadline[i] = '0;
          if (!btn_lock_q[i]) btn_down[i] = phys_latch[i];
        end
      end else if (!btn_forced[i] && !btn_lock_q[i]) begin
        btn_down[i] = phys_latch[i];
      end
    end
  endfunction

  function automatic report_t predict_report(mbor_pkg::item_t it);
    report_t            r;
    int                 b;
    logic [31:0]        pd;
    logic [31:0]        rd;
    logic signed [8:0]  sw;
    r = '0;
    b = int'(it.button_index);
    case (it.opcode)
      mbor_pkg::OpTick: begin
        tick_buttons(it.now_ms);
        if (notify_q && btn_down != last_mask) begin
          r.mask_changed = 1'b1;
          last_mask = btn_down;
        end
      end
      mbor_pkg::OpPhys: begin
        phys_latch = it.physical_mask;
        for (int i = 0; i < mbor_pkg::NumButtons; i++)
          if (!btn_forced[i] && !btn_lock_q[i]) btn_down[i] = phys_latch[i];
      end
      mbor_pkg::OpForce: begin
        if (b < mbor_pkg::NumButtons) begin
          if (it.press) begin
            btn_down[b]     = 1'b1;
            btn_forced[b]   = 1'b1;
            rel_deadline[b] = '0;
            btn_clicking[b] = 1'b0;
          end else if (btn_forced[b] && btn_down[b]) begin
            btn_down[b]     = 1'b0;
            rel_deadline[b] = it.now_ms + draw_ms(RelLo, RelHi);
            btn_clicking[b] = 1'b0;
          end
        end
      end
      mbor_pkg::OpClick: begin
        if (b < mbor_pkg::NumButtons) begin
          btn_clicking[b] = 1'b1;
          btn_down[b]     = 1'b1;
          btn_forced[b]   = 1'b1;
          pd = draw_ms(PressLo, PressHi);
          rd = draw_ms(RelLo, RelHi);
          click_rel_at[b] = it.now_ms + pd;
          click_end_at[b] = click_rel_at[b] + rd;
          rel_deadline[b] = '0;
        end
      end
      mbor_pkg::OpMove: begin
        if (!lock_x_q) acc_x = add_sat32(acc_x, it.move_dx);
        if (!lock_y_q) acc_y = add_sat32(acc_y, it.move_dy);
      end
      mbor_pkg::OpWheel: begin
        sw = $signed({acc_wheel[7], acc_wheel}) + $signed({it.wheel_delta[7], it.wheel_delta});
        if (sw[8] != sw[7]) acc_wheel = sw[8] ? 8'h80 : 8'h7F;
        else acc_wheel = sw[7:0];
      end
      mbor_pkg::OpRead: begin
        r.report_x     = drain_chunk(acc_x);
        r.report_y     = drain_chunk(acc_y);
        r.report_wheel = acc_wheel;
        acc_wheel      = '0;
      end
      default: ;
    endcase
    r.report_buttons = btn_down;
    r.any_forced     = |btn_forced;
    return r;
  endfunction

  function automatic mbor_pkg::item_t mk_item(mbor_pkg::op_e op, logic [31:0] now,
                                              logic [2:0] idx, logic press,
                                              logic [4:0] phys, logic [15:0] dx,
                                              logic [15:0] dy, logic [7:0] wd);
    mbor_pkg::item_t it;
    it.opcode        = op;
    it.now_ms        = now;
    it.button_index  = idx;
    it.press         = press;
    it.physical_mask = phys;
    it.move_dx       = dx;
    it.move_dy       = dy;
    it.wheel_delta   = wd;
    return it;
  endfunction

  function automatic report_t mk_report(logic [4:0] btn, logic [7:0] x, logic [7:0] y,
                                        logic [7:0] w, logic chg, logic anyf);
    report_t r;
    r.report_buttons = btn;
    r.report_x       = x;
    r.report_y       = y;
    r.report_wheel   = w;
    r.mask_changed   = chg;
    r.any_forced     = anyf;
    return r;
  endfunction

  function automatic void add_row(mbor_pkg::item_t it, bit typed = 1'b0, report_t want = '0);
    stim_row_t row;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [15:0] rand_delta();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 64) - 32);
  endfunction

  function automatic mbor_pkg::item_t rand_item();
    mbor_pkg::item_t it;
    int              pick;
    pick = $urandom_range(0, 99);
    it.opcode        = mbor_pkg::OpRead;
    it.now_ms        = $urandom;
    it.button_index  = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4))
                                                    : 3'($urandom_range(5, 7));
    it.press         = 1'($urandom_range(0, 1));
    it.physical_mask = 5'($urandom_range(0, 31));
    it.move_dx       = rand_delta();
    it.move_dy       = rand_delta();
    it.wheel_delta   = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 6) - 3);
    // rare time jumps push the clock through its full range and across wrap
    if ($urandom_range(0, 99) < 2) sim_ms = $urandom;
    if (pick < 32) begin
      it.opcode = mbor_pkg::OpTick;
      sim_ms += ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(0, 40);
      it.now_ms = sim_ms;
    end else if (pick < 42) begin
      it.opcode = mbor_pkg::OpPhys;
    end else if (pick < 54) begin
      it.opcode = mbor_pkg::OpForce;
      it.now_ms = sim_ms;
    end else if (pick < 63) begin
      it.opcode = mbor_pkg::OpClick;
      it.now_ms = sim_ms;
    end else if (pick < 75) begin
      it.opcode = mbor_pkg::OpMove;
    end else if (pick < 85) begin
      it.opcode = mbor_pkg::OpWheel;
    end else if (pick < 98) begin
      it.opcode = mbor_pkg::OpRead;
    end else begin
      it.opcode = mbor_pkg::op_e'(OpUnused);
    end
    return it;
  endfunction

  task automatic send_item(mbor_pkg::item_t it, bit typed, report_t want);
    int      gap;
    report_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.opcode        <= it.opcode;
    item_if.now_ms        <= it.now_ms;
    item_if.button_index  <= it.button_index;
    item_if.press         <= it.press;
    item_if.physical_mask <= it.physical_mask;
    item_if.move_dx       <= it.move_dx;
    item_if.move_dy       <= it.move_dy;
    item_if.wheel_delta   <= it.wheel_delta;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    pred = predict_report(it);
    expected_reports.push_back(typed ? want : pred);
  endtask

  task automatic write_cfg(mbor_pkg::cfg_e idx, logic [mbor_pkg::CfgDataBits-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      mbor_pkg::CfgLockX:   lock_x_q   = val[0];
      mbor_pkg::CfgLockY:   lock_y_q   = val[0];
      mbor_pkg::CfgBtnLock: btn_lock_q = val[4:0];
      mbor_pkg::CfgNotify:  notify_q   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic lx, logic ly, logic [4:0] lock_mask, logic notify);
    write_cfg(mbor_pkg::CfgLockX, mbor_pkg::CfgDataBits'(lx));
    write_cfg(mbor_pkg::CfgLockY, mbor_pkg::CfgDataBits'(ly));
    write_cfg(mbor_pkg::CfgBtnLock, lock_mask);
    write_cfg(mbor_pkg::CfgNotify, mbor_pkg::CfgDataBits'(notify));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // result sink with random backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      report_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      report_if.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      report_if.ready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && report_if.valid && report_if.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report transaction, expected none, actual buttons %0h",
                 $time, report_if.report_buttons);
        mismatches++;
      end else begin
        want_rep = expected_reports.pop_front();
        check_field("report_buttons", want_rep.report_buttons, report_if.report_buttons);
        check_field("report_x", want_rep.report_x, report_if.report_x);
        check_field("report_y", want_rep.report_y, report_if.report_y);
        check_field("report_wheel", want_rep.report_wheel, report_if.report_wheel);
        check_field("mask_changed", want_rep.mask_changed, report_if.mask_changed);
        check_field("any_forced", want_rep.any_forced, report_if.any_forced);
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (report_if.valid && report_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_mouse_button_override_report: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = mbor_pkg::CfgLockX;
    cfg_data              = '0;
    item_if.valid         = 1'b0;
    item_if.opcode        = mbor_pkg::OpTick;
    item_if.now_ms        = '0;
    item_if.button_index  = '0;
    item_if.press         = 1'b0;
    item_if.physical_mask = '0;
    item_if.move_dx       = '0;
    item_if.move_dy       = '0;
    item_if.wheel_delta   = '0;
    report_if.ready       = 1'b0;
    sim_ms                = $urandom_range(0, 1000);

    // accumulator extremes, drain chunks, force and click corner cases
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_report(0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpMove, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 0), 1, '0);
    add_row(mk_item(mbor_pkg::OpMove, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 0), 1, '0);
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_report(0, 8'h7F, 8'h80, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpWheel, 0, 0, 0, 0, 0, 0, 8'h7F), 1, '0);
    add_row(mk_item(mbor_pkg::OpWheel, 0, 0, 0, 0, 0, 0, 8'h7F), 1, '0);
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_report(0, 8'h7F, 8'h80, 8'h7F, 0, 0));
    add_row(mk_item(mbor_pkg::OpWheel, 0, 0, 0, 0, 0, 0, 8'h80), 1, '0);
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_report(0, 8'h7F, 8'h80, 8'h80, 0, 0));
    add_row(mk_item(mbor_pkg::OpPhys, 0, 0, 0, 5'h1F, 0, 0, 0), 1,
            mk_report(5'h1F, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpForce, 0, 4, 1, 0, 0, 0, 0), 1,
            mk_report(5'h1F, 0, 0, 0, 0, 1));
    // timed release whose deadline wraps past zero
    add_row(mk_item(mbor_pkg::OpForce, 32'hFFFF_FFC0, 4, 0, 0, 0, 0, 0));
    // release of a button that is not forced is dropped
    add_row(mk_item(mbor_pkg::OpForce, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_report(5'h0F, 0, 0, 0, 0, 1));
    add_row(mk_item(mbor_pkg::OpClick, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpTick, 100, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpTick, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpForce, 0, 5, 1, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpClick, 0, 7, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::op_e'(OpUnused), 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpPhys, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpTick, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpMove, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 0));
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(mbor_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1'b0, 1'b0, 5'h00, 1'b0);
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      case (ph)
        0: set_config(1'b1, 1'b1, 5'h1F, 1'b1);
        1: set_config(1'b0, 1'b0, 5'h00, 1'b1);
        2: set_config(1'b0, 1'b0, 5'h00, 1'b0);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      endcase
      no_idle = (ph == 2 || ph == 5);
      for (int n = 0; n < PhaseItems; n++) send_item(rand_item(), 1'b0, '0);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_mouse_button_override_report: done, clean");
    end else begin
      $display("tb_mouse_button_override_report: done, errors");
    end
    $finish;
  end

endmodule
